>>> rtl/core/pcp_pkg.sv
// Shared codes and control structs for the point-in-convex-polygon unit.
package pcp_pkg;

    // Command kind carried by an input beat
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // Kind of work a pipeline token carries through the edge unit
    localparam logic [2:0] K_VERT0 = 3'd0;  // first vertex: capture only
    localparam logic [2:0] K_EDGE  = 3'd1;  // stored vertex closes an edge with the previous one
    localparam logic [2:0] K_CLOSE = 3'd2;  // closing edge back to vertex 0
    localparam logic [2:0] K_DOT   = 3'd3;  // segment test: dot product
    localparam logic [2:0] K_LEN   = 3'd4;  // segment test: squared length

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [2:0] kind;
    } t_tok;

    typedef struct packed {
        logic eq;          // point equals vertex 0
        logic seg_zero;    // edge has zero length
        logic pt_on_o;     // point equals the edge origin
        logic any_neg;     // some edge cross product below zero
        logic any_pos;     // some edge cross product above zero
        logic dot_neg;     // dot product below zero
        logic len_lt_dot;  // squared length below dot product
        logic fin;         // last token has left the pipeline
    } t_stat;

endpackage

>>> rtl/core/pcp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/pcp_edge_unit.sv
// Edge pipeline: differences, products and sign accumulation per vertex beat.
module pcp_edge_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  pcp_pkg::t_tok                 i_tok,
    input  logic signed [COORD_WIDTH-1:0] i_vx,
    input  logic signed [COORD_WIDTH-1:0] i_vy,
    input  logic signed [COORD_WIDTH-1:0] i_px,
    input  logic signed [COORD_WIDTH-1:0] i_py,
    output pcp_pkg::t_stat                o_stat
);
    import pcp_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;     // coordinate difference
    localparam int PW = 2 * DW;     // one product
    localparam int SW = PW + 1;     // sum or difference of two products

    // stage 1 state
    logic signed [CW-1:0] r_v0x, r_v0y, r_ox, r_oy;
    logic signed [DW-1:0] r_sx, r_sy, r_dx, r_dy;
    logic                 r_eq, r_seg_zero, r_pt_on_o;
    t_tok                 r_t2, r_t3;
    // stage 2 state
    logic signed [PW-1:0] r_m1, r_m2;
    // stage 3 state
    logic signed [SW-1:0] r_dot, r_len;
    logic                 r_any_neg, r_any_pos, r_fin;

    logic signed [CW-1:0] w_ax, w_ay;
    logic signed [DW-1:0] w_m1a, w_m1b, w_m2a, w_m2b;
    logic signed [SW-1:0] w_sum;
    logic                 w_sub;
    logic signed [SW:0]   w_ld;

    // stage 1: closing edge reuses vertex 0 instead of the RAM word
    assign w_ax = (i_tok.kind == K_CLOSE) ? r_v0x : i_vx;
    assign w_ay = (i_tok.kind == K_CLOSE) ? r_v0y : i_vy;

    always_ff @(posedge i_clk) begin
        if (i_tok.valid) begin
            unique case (i_tok.kind)
                K_VERT0: begin
                    r_v0x <= w_ax;
                    r_v0y <= w_ay;
                    r_ox  <= w_ax;
                    r_oy  <= w_ay;
                    r_eq  <= (w_ax == i_px) && (w_ay == i_py);
                end
                K_EDGE, K_CLOSE: begin
                    r_sx       <= {w_ax[CW-1], w_ax} - {r_ox[CW-1], r_ox};
                    r_sy       <= {w_ay[CW-1], w_ay} - {r_oy[CW-1], r_oy};
                    r_dx       <= {i_px[CW-1], i_px} - {r_ox[CW-1], r_ox};
                    r_dy       <= {i_py[CW-1], i_py} - {r_oy[CW-1], r_oy};
                    r_seg_zero <= (w_ax == r_ox) && (w_ay == r_oy);
                    r_pt_on_o  <= (i_px == r_ox) && (i_py == r_oy);
                    r_ox       <= w_ax;
                    r_oy       <= w_ay;
                end
                default: begin
                    // dot and length beats reuse the held differences
                end
            endcase
        end
    end

    // stage 2: operand selection for the product pair
    always_comb begin
        w_m1a = r_sx;
        w_m1b = r_dy;
        w_m2a = r_sy;
        w_m2b = r_dx;
        unique case (r_t2.kind)
            K_DOT: begin
                w_m1a = r_dx;
                w_m1b = r_sx;
                w_m2a = r_dy;
                w_m2b = r_sy;
            end
            K_LEN: begin
                w_m1a = r_sx;
                w_m1b = r_sx;
                w_m2a = r_sy;
                w_m2b = r_sy;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_m1 <= w_m1a * w_m1b;
        r_m2 <= w_m2a * w_m2b;
    end

    // stage 3: cross product is m1 - m2, dot and length are m1 + m2
    assign w_sub = (r_t3.kind == K_EDGE) || (r_t3.kind == K_CLOSE);
    assign w_sum = w_sub ? (SW'(r_m1) - SW'(r_m2)) : (SW'(r_m1) + SW'(r_m2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_any_neg <= 1'b0;
            r_any_pos <= 1'b0;
        end else if (r_t3.valid && w_sub) begin
            r_any_neg <= r_any_neg | w_sum[SW-1];
            r_any_pos <= r_any_pos | (!w_sum[SW-1] && (|w_sum));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_t3.valid && (r_t3.kind == K_DOT)) begin
            r_dot <= w_sum;
        end
        if (r_t3.valid && (r_t3.kind == K_LEN)) begin
            r_len <= w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t2.valid <= 1'b0;
            r_t2.last  <= 1'b0;
            r_t2.kind  <= K_VERT0;
            r_t3.valid <= 1'b0;
            r_t3.last  <= 1'b0;
            r_t3.kind  <= K_VERT0;
            r_fin      <= 1'b0;
        end else begin
            r_t2  <= i_tok;
            r_t3  <= r_t2;
            r_fin <= r_t3.valid && r_t3.last;
        end
    end

    assign w_ld = (SW+1)'(r_len) - (SW+1)'(r_dot);

    assign o_stat.eq         = r_eq;
    assign o_stat.seg_zero   = r_seg_zero;
    assign o_stat.pt_on_o    = r_pt_on_o;
    assign o_stat.any_neg    = r_any_neg;
    assign o_stat.any_pos    = r_any_pos;
    assign o_stat.dot_neg    = r_dot[SW-1];
    assign o_stat.len_lt_dot = w_ld[SW];
    assign o_stat.fin        = r_fin;

endmodule

>>> rtl/core/point_in_convex_polygon_unit.sv
// Top level: vertex store, query sequencer and inside decision.
//
//  channel   direction  handshake                   payload
//  command   in         start, busy                 i_op, i_vertex_index, i_coord_x, i_coord_y
//  result    out        o_res_strobe (one cycle)    o_inside_res
//  config    in         i_cfg_we                    i_cfg_wdata (vertex_count)
//
// A write beat leaves busy low. A query beat reads one vertex per cycle from the
// vertex RAM and streams edges through a three-stage product pipeline; the strobe
// is high in the first cycle busy is low.
// Reset is synchronous; the vertex RAM is not cleared and holds garbage until
// written. The result side has no stall: each strobe beat is taken as it appears.
module point_in_convex_polygon_unit #(
    parameter int MAX_VERTICES = 32,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [4:0]                    i_vertex_index,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    output logic                          o_res_strobe,
    output logic                          o_inside_res,
    input  logic                          i_cfg_we,
    input  logic [5:0]                    i_cfg_wdata
);
    import pcp_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]           r_state;
    logic [5:0]           r_vertex_count;
    logic [NW-1:0]        r_n, r_step, n_n;
    logic signed [CW-1:0] r_px, r_py;
    logic                 r_strobe, r_inside;
    t_tok                 r_t1;
    t_stat                w_stat;

    logic                 w_accept, w_ram_we, w_last, w_inside;
    logic [2:0]           w_kind;
    logic [AW-1:0]        w_waddr;
    logic [2*CW-1:0]      w_rdata;

    assign w_accept = start && !busy;
    assign w_ram_we = w_accept && (i_op == OP_WRITE)
                      && (32'(i_vertex_index) < MAX_VERTICES);
    assign w_waddr  = AW'(i_vertex_index);

    // counts above the store saturate
    assign n_n = (32'(r_vertex_count) > MAX_VERTICES) ? NW'(MAX_VERTICES)
                                                      : NW'(r_vertex_count);

    pcp_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_VERTICES)
    ) u_vert_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata ({i_coord_y, i_coord_x}),
        .i_raddr (r_step[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // beat schedule: vertex 0, then edges; two vertices add dot and length beats
    always_comb begin
        if (r_step == '0) begin
            w_kind = K_VERT0;
        end else if (r_n == NW'(2)) begin
            w_kind = (r_step == NW'(1)) ? K_EDGE :
                     (r_step == NW'(2)) ? K_DOT  : K_LEN;
        end else begin
            w_kind = (r_step == r_n) ? K_CLOSE : K_EDGE;
        end
    end

    always_comb begin
        priority if (r_n == NW'(1)) begin
            w_last = (r_step == '0);
        end else if (r_n == NW'(2)) begin
            w_last = (r_step == NW'(3));
        end else begin
            w_last = (r_step == r_n);
        end
    end

    pcp_edge_unit #(
        .COORD_WIDTH (CW)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_accept),
        .i_tok   (r_t1),
        .i_vx    (w_rdata[CW-1:0]),
        .i_vy    (w_rdata[2*CW-1:CW]),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_stat  (w_stat)
    );

    always_comb begin
        priority if (r_n == NW'(1)) begin
            w_inside = w_stat.eq;
        end else if (r_n == NW'(2)) begin
            // coincident endpoints: the point must sit on them
            w_inside = w_stat.seg_zero ? w_stat.pt_on_o
                     : (!w_stat.any_neg && !w_stat.any_pos
                        && !w_stat.dot_neg && !w_stat.len_lt_dot);
        end else if (r_n == NW'(3)) begin
            w_inside = !(w_stat.any_neg && w_stat.any_pos);
        end else begin
            w_inside = !w_stat.any_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= 6'd3;
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_strobe   <= 1'b0;
            r_t1.valid <= 1'b0;
            r_t1.last  <= 1'b0;
            r_t1.kind  <= K_VERT0;
            r_step     <= '0;
            r_n        <= '0;
        end else begin
            r_strobe   <= 1'b0;
            r_t1.valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && (i_op != OP_WRITE)) begin
                        r_n    <= n_n;
                        r_step <= '0;
                        if (n_n == '0) begin
                            r_strobe <= 1'b1;
                        end else begin
                            r_state <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    r_t1.valid <= 1'b1;
                    r_t1.last  <= w_last;
                    r_t1.kind  <= w_kind;
                    r_step     <= r_step + NW'(1);
                    if (w_last) begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (w_stat.fin) begin
                        r_strobe <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_op != OP_WRITE)) begin
            r_px     <= i_coord_x;
            r_py     <= i_coord_y;
            r_inside <= 1'b0;
        end else if ((r_state == ST_WAIT) && w_stat.fin) begin
            r_inside <= w_inside;
        end
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_res_strobe = r_strobe;
    assign o_inside_res = r_inside;

    // a result beat only follows a drained query or an empty-polygon query
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past((r_state == ST_WAIT) || (w_accept && i_op)))
        else $error("result strobe without a finishing query");

    // leaving a query always delivers its result in the same cycle
    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_res_strobe)
        else $error("query ended without a result beat");

    // the pipeline only drains while the sequencer waits for it
    a_fin_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.fin |-> (r_state == ST_WAIT))
        else $error("edge pipeline finished outside the wait state");

    // outside the two-vertex case, the beat counter never runs past the closing edge
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> ((r_step <= r_n) || (r_n == NW'(2))))
        else $error("beat counter beyond vertex count");

    // no vertex write lands while a query reads the store
    a_no_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_t1.valid || w_stat.fin) |-> !w_ram_we)
        else $error("vertex store written during a query");

endmodule
